[design/ore_pkg.sv]
// Shared constants, register indexes and the moving-average helper for the occupancy rate block.
`default_nettype none

package ore_pkg;

    localparam int TS_W    = 64;   // timestamp counter width
    localparam int MUL_W   = 16;   // tick-to-ns numerator and denominator width
    localparam int SHIFT_W = 4;    // averaging weight shift width
    localparam int DNS_W   = 48;   // elapsed-ns width
    localparam int RATE_W  = 32;   // Q16.16 rate width
    localparam int PROD_W  = TS_W + MUL_W;
    localparam int EWMA_W  = RATE_W + (2 ** SHIFT_W);
    localparam int CFG_IDX_W = 2;

    localparam int COUNTER_BITS_DEF = 48;
    localparam int FRAC_BITS_DEF    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NS_MUL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NS_DIV    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_SHF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_SHF  = 2'd3;

    localparam logic [MUL_W-1:0]   NS_MUL_RST    = 16'd10;
    localparam logic [MUL_W-1:0]   NS_DIV_RST    = 16'd21;
    localparam logic [SHIFT_W-1:0] SHORT_SHF_RST = 4'd3;
    localparam logic [SHIFT_W-1:0] LONG_SHF_RST  = 4'd8;

    localparam logic [DNS_W-1:0]  DNS_SAT  = {DNS_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_SAT = {RATE_W{1'b1}};

    // avg = floor((avg * (2^k - 1) + x) / 2^k)
    function automatic logic [RATE_W-1:0] ewma_step(
        input logic [RATE_W-1:0]  prev,
        input logic [RATE_W-1:0]  x,
        input logic [SHIFT_W-1:0] k
    );
        logic [EWMA_W-1:0] acc;
        logic [EWMA_W-1:0] shr;
        acc = (EWMA_W'(prev) << k) - EWMA_W'(prev) + EWMA_W'(x);
        shr = acc >> k;
        return shr[RATE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/occupancy_rate_ewma.sv]
// Occupancy rate block: sequencer, shared divide step, moving averages and result register.
//
// Usage: the sample channel (item_valid/item_ready) takes one request with an
// occupancy counter sample and a timestamp sample. The report channel
// (report_valid/report_ready) returns exactly one result per request. The cfg
// channel writes registers by index and is always ready; write it only while idle.
// Sequence: the first sample after reset only primes state; the sequencer goes
// straight to its result state, which loads the report register. Otherwise the
// multiply takes one bit of ns_multiplier a cycle, then the tick-to-ns division
// and the rate division, each after a saturation check, run through the single
// restoring divide-step unit, then the two averages and the result load follow;
// a division is skipped when its quotient saturates, and the rate division and
// averaging when elapsed time is zero. A new request is taken in the cycle after
// the result is loaded into the report register, never while one is in progress.
// Stall: the report register holds its result while report_ready is low; the
// next request may be taken and computed meanwhile, but its result waits in
// the sequencer until the report register frees.
// Reset: clears the averages, the primed flag and the control state, and loads
// the default register values (10, 21, 3, 8).
`default_nettype none

module occupancy_rate_ewma
    import ore_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire logic [COUNTER_BITS-1:0] occupancy_count,
    input  wire logic [TS_W-1:0]         timestamp,

    output logic                         report_valid,
    input  wire logic                    report_ready,
    output logic                         result_valid,
    output logic      [DNS_W-1:0]        delta_ns,
    output logic      [RATE_W-1:0]       rate_now,
    output logic      [RATE_W-1:0]       rate_short,
    output logic      [RATE_W-1:0]       rate_long,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [MUL_W-1:0]        cfg_data
);

    localparam int NUM_W = COUNTER_BITS + FRAC_BITS;
    localparam int NUM_X = (NUM_W > RATE_W) ? NUM_W : RATE_W + 1;
    localparam int HI_W  = (NUM_X - RATE_W > DNS_W) ? NUM_X - RATE_W : DNS_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_NSCHK = 4'd2;
    localparam logic [3:0] ST_NSDIV = 4'd3;
    localparam logic [3:0] ST_RCHK  = 4'd4;
    localparam logic [3:0] ST_RDIV  = 4'd5;
    localparam logic [3:0] ST_EWS   = 4'd6;
    localparam logic [3:0] ST_EWL   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic                    primed_reg, primed_next;
    logic [RATE_W-1:0]       avg_short_reg, avg_short_next;
    logic [RATE_W-1:0]       avg_long_reg, avg_long_next;
    logic [MUL_W-1:0]        mul_reg, mul_next;
    logic [MUL_W-1:0]        div_reg, div_next;
    logic [SHIFT_W-1:0]      kshort_reg, kshort_next;
    logic [SHIFT_W-1:0]      klong_reg, klong_next;
    logic                    report_valid_reg, report_valid_next;

    logic [COUNTER_BITS-1:0] last_occ_reg, last_occ_next;
    logic [TS_W-1:0]         last_ts_reg, last_ts_next;
    logic [TS_W-1:0]         ticks_reg, ticks_next;
    logic [COUNTER_BITS-1:0] diff_reg, diff_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [DNS_W-1:0]        rem_reg, rem_next;
    logic [DNS_W-1:0]        quo_reg, quo_next;
    logic [DNS_W-1:0]        dns_reg, dns_next;
    logic [RATE_W-1:0]       rate_reg, rate_next;
    logic                    ok_reg, ok_next;
    logic                    out_ok_reg;
    logic [DNS_W-1:0]        out_dns_reg;
    logic [RATE_W-1:0]       out_rate_reg;
    logic [RATE_W-1:0]       out_short_reg;
    logic [RATE_W-1:0]       out_long_reg;

    logic [MUL_W-1:0]        div_eff;
    logic [NUM_X-1:0]        num_x;
    logic [HI_W-1:0]         hi_ext;
    logic [PROD_W-DNS_W-1:0] hi_ns;
    logic                    load_out;
    logic                    step_din;
    logic [DNS_W-1:0]        step_divisor;
    logic [DNS_W-1:0]        step_rem;
    logic                    step_q;

    assign div_eff = (div_reg == '0) ? MUL_W'(1) : div_reg;
    assign num_x   = {{(NUM_X - COUNTER_BITS){1'b0}}, diff_reg} << FRAC_BITS;
    assign hi_ext  = HI_W'(num_x[NUM_X-1:RATE_W]);
    assign hi_ns   = acc_reg[PROD_W-1:DNS_W];

    assign step_din     = (state_reg == ST_NSDIV) ? quo_reg[DNS_W-1] : quo_reg[RATE_W-1];
    assign step_divisor = (state_reg == ST_NSDIV) ? DNS_W'(div_eff) : dns_reg;

    ore_div_step u_div_step (
        .rem      (rem_reg),
        .din      (step_din),
        .divisor  (step_divisor),
        .rem_next (step_rem),
        .qbit     (step_q)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign load_out   = (state_reg == ST_FIN) && (!report_valid_reg || report_ready);

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        primed_next       = primed_reg;
        avg_short_next    = avg_short_reg;
        avg_long_next     = avg_long_reg;
        mul_next          = mul_reg;
        div_next          = div_reg;
        kshort_next       = kshort_reg;
        klong_next        = klong_reg;
        last_occ_next     = last_occ_reg;
        last_ts_next      = last_ts_reg;
        ticks_next        = ticks_reg;
        diff_next         = diff_reg;
        acc_next          = acc_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        dns_next          = dns_reg;
        rate_next         = rate_reg;
        ok_next           = ok_reg;

        if (load_out)
        begin
            report_valid_next = 1'b1;
        end
        else if (report_ready)
        begin
            report_valid_next = 1'b0;
        end
        else
        begin
            report_valid_next = report_valid_reg;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NS_MUL:    mul_next    = cfg_data;
                REG_NS_DIV:    div_next    = cfg_data;
                REG_SHORT_SHF: kshort_next = cfg_data[SHIFT_W-1:0];
                REG_LONG_SHF:  klong_next  = cfg_data[SHIFT_W-1:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    last_occ_next = occupancy_count;
                    last_ts_next  = timestamp;
                    primed_next   = 1'b1;
                    ticks_next    = timestamp - last_ts_reg;
                    diff_next     = occupancy_count - last_occ_reg;
                    acc_next      = '0;
                    cnt_next      = 6'(MUL_W - 1);
                    if (primed_reg)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        dns_next   = '0;
                        rate_next  = '0;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MUL:
            begin
                // multiplier bits MSB first
                acc_next = (acc_reg << 1)
                         + (mul_reg[cnt_reg[3:0]] ? PROD_W'(ticks_reg) : '0);
                if (cnt_reg == '0)
                begin
                    state_next = ST_NSCHK;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ST_NSCHK:
            begin
                // quotient >= 2^48 exactly when the top bits reach the divisor
                if (hi_ns >= (PROD_W - DNS_W)'(div_eff))
                begin
                    dns_next   = DNS_SAT;
                    state_next = ST_RCHK;
                end
                else
                begin
                    rem_next   = DNS_W'(hi_ns[MUL_W-1:0]);
                    quo_next   = acc_reg[DNS_W-1:0];
                    cnt_next   = 6'(DNS_W - 1);
                    state_next = ST_NSDIV;
                end
            end
            ST_NSDIV:
            begin
                rem_next = step_rem;
                quo_next = {quo_reg[DNS_W-2:0], step_q};
                if (cnt_reg == '0)
                begin
                    dns_next   = {quo_reg[DNS_W-2:0], step_q};
                    state_next = ST_RCHK;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ST_RCHK:
            begin
                if (dns_reg == '0)
                begin
                    ok_next    = 1'b0;
                    rate_next  = '0;
                    state_next = ST_FIN;
                end
                else if (hi_ext >= HI_W'(dns_reg))
                begin
                    rate_next  = RATE_SAT;
                    state_next = ST_EWS;
                end
                else
                begin
                    rem_next   = hi_ext[DNS_W-1:0];
                    quo_next   = DNS_W'(num_x[RATE_W-1:0]);
                    cnt_next   = 6'(RATE_W - 1);
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV:
            begin
                rem_next = step_rem;
                quo_next = {quo_reg[DNS_W-2:0], step_q};
                if (cnt_reg == '0)
                begin
                    rate_next  = {quo_reg[RATE_W-2:0], step_q};
                    state_next = ST_EWS;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ST_EWS:
            begin
                avg_short_next = ewma_step(avg_short_reg, rate_reg, kshort_reg);
                state_next     = ST_EWL;
            end
            ST_EWL:
            begin
                avg_long_next = ewma_step(avg_long_reg, rate_reg, klong_reg);
                ok_next       = 1'b1;
                state_next    = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            primed_reg       <= 1'b0;
            avg_short_reg    <= '0;
            avg_long_reg     <= '0;
            mul_reg          <= NS_MUL_RST;
            div_reg          <= NS_DIV_RST;
            kshort_reg       <= SHORT_SHF_RST;
            klong_reg        <= LONG_SHF_RST;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            primed_reg       <= primed_next;
            avg_short_reg    <= avg_short_next;
            avg_long_reg     <= avg_long_next;
            mul_reg          <= mul_next;
            div_reg          <= div_next;
            kshort_reg       <= kshort_next;
            klong_reg        <= klong_next;
            report_valid_reg <= report_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_occ_reg <= last_occ_next;
        last_ts_reg  <= last_ts_next;
        ticks_reg    <= ticks_next;
        diff_reg     <= diff_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dns_reg      <= dns_next;
        rate_reg     <= rate_next;
        ok_reg       <= ok_next;
        if (load_out)
        begin
            out_ok_reg    <= ok_reg;
            out_dns_reg   <= dns_reg;
            out_rate_reg  <= rate_reg;
            out_short_reg <= avg_short_reg;
            out_long_reg  <= avg_long_reg;
        end
    end

    assign report_valid = report_valid_reg;
    assign result_valid = out_ok_reg;
    assign delta_ns     = out_dns_reg;
    assign rate_now     = out_rate_reg;
    assign rate_short   = out_short_reg;
    assign rate_long    = out_long_reg;

`ifndef NO_ASSERTIONS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !result_valid |-> rate_now == '0 && delta_ns == '0)
        else $error("invalid report carries nonzero rate or delta");

    a_valid_nonzero_dns: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && result_valid |-> delta_ns != '0)
        else $error("valid report with zero elapsed time");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("sample request taken while still busy");

    a_primed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped");
`endif

endmodule

`default_nettype wire

[design/ore_div_step.sv]
// One restoring division step, shared by the tick-to-ns and the rate division.
`default_nettype none

module ore_div_step
    import ore_pkg::*;
(
    input  wire logic [DNS_W-1:0] rem,
    input  wire logic             din,
    input  wire logic [DNS_W-1:0] divisor,
    output logic      [DNS_W-1:0] rem_next,
    output logic                  qbit
);

    logic [DNS_W:0] trial;
    logic [DNS_W:0] sub;

    assign trial    = {rem, din};
    assign sub      = trial - {1'b0, divisor};
    assign qbit     = (trial >= {1'b0, divisor});
    // remainder stays below the divisor, so it fits DNS_W bits
    assign rem_next = qbit ? sub[DNS_W-1:0] : trial[DNS_W-1:0];

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for occupancy_rate_ewma: directed edge cases, register sweeps, random traffic.
`timescale 1ns / 1ps

module tb_top
    import ore_pkg::*;
();

    localparam int OCC_W       = COUNTER_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 120;

    typedef struct packed {
        logic              valid;
        logic [DNS_W-1:0]  dns;
        logic [RATE_W-1:0] now;
        logic [RATE_W-1:0] fast_avg;
        logic [RATE_W-1:0] slow_avg;
    } rate_report_t;

    logic                 clk;
    logic                 rst_n           = 1'b0;
    logic                 item_valid      = 1'b0;
    logic                 item_ready;
    logic [OCC_W-1:0]     occupancy_count = '0;
    logic [TS_W-1:0]      timestamp       = '0;
    logic                 report_valid;
    logic                 report_ready    = 1'b0;
    logic                 result_valid;
    logic [DNS_W-1:0]     delta_ns;
    logic [RATE_W-1:0]    rate_now;
    logic [RATE_W-1:0]    rate_short;
    logic [RATE_W-1:0]    rate_long;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [MUL_W-1:0]     cfg_data        = '0;

    // predictor copy of registers and state
    logic [MUL_W-1:0]   reg_mul    = NS_MUL_RST;
    logic [MUL_W-1:0]   reg_div    = NS_DIV_RST;
    logic [SHIFT_W-1:0] reg_fast_k = SHORT_SHF_RST;
    logic [SHIFT_W-1:0] reg_slow_k = LONG_SHF_RST;
    logic [OCC_W-1:0]   pred_last_occ = '0;
    logic [TS_W-1:0]    pred_last_ts  = '0;
    logic               pred_primed   = 1'b0;
    logic [RATE_W-1:0]  pred_fast     = '0;
    logic [RATE_W-1:0]  pred_slow     = '0;

    // stimulus cursor: last sample sent
    logic [OCC_W-1:0] stim_occ = '0;
    logic [TS_W-1:0]  stim_ts  = '0;

    rate_report_t expected_reports[$];
    int mismatches   = 0;
    int reports_seen = 0;
    int cycle_count  = 0;

    occupancy_rate_ewma DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .occupancy_count (occupancy_count),
        .timestamp       (timestamp),
        .report_valid    (report_valid),
        .report_ready    (report_ready),
        .result_valid    (result_valid),
        .delta_ns        (delta_ns),
        .rate_now        (rate_now),
        .rate_short      (rate_short),
        .rate_long       (rate_long),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // floor(ticks * mul / div) on the full 80-bit product, saturated to 48 bits
    function automatic logic [DNS_W-1:0] ticks_to_ns(input logic [TS_W-1:0] ticks,
                                                     input logic [MUL_W-1:0] mul,
                                                     input logic [MUL_W-1:0] div);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quo;
        logic [MUL_W-1:0]  den;
        den  = (div == '0) ? MUL_W'(1) : div;
        prod = PROD_W'(ticks) * PROD_W'(mul);
        quo  = prod / PROD_W'(den);
        return (quo > PROD_W'(DNS_SAT)) ? DNS_SAT : quo[DNS_W-1:0];
    endfunction

    // Q16.16 occupancy per ns, saturated to 32 bits
    function automatic logic [RATE_W-1:0] rate_q16(input logic [OCC_W-1:0] diff,
                                                   input logic [DNS_W-1:0] dns);
        logic [63:0] num;
        logic [63:0] quo;
        num = 64'(diff) << FRAC_BITS_DEF;
        quo = num / 64'(dns);
        return (quo > 64'(RATE_SAT)) ? RATE_SAT : quo[RATE_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] smooth(input logic [RATE_W-1:0] prev,
                                                 input logic [RATE_W-1:0] x,
                                                 input logic [SHIFT_W-1:0] k);
        logic [63:0] acc;
        acc = (64'(prev) << k) - 64'(prev) + 64'(x);
        acc = acc >> k;
        return acc[RATE_W-1:0];
    endfunction

    function automatic rate_report_t predict_report(input logic [OCC_W-1:0] occ,
                                                    input logic [TS_W-1:0] ts);
        rate_report_t r;
        r.valid = 1'b0;
        r.dns   = '0;
        r.now   = '0;
        if (pred_primed)
        begin
            r.dns = ticks_to_ns(ts - pred_last_ts, reg_mul, reg_div);
            if (r.dns != '0)
            begin
                r.now     = rate_q16(occ - pred_last_occ, r.dns);
                pred_fast = smooth(pred_fast, r.now, reg_fast_k);
                pred_slow = smooth(pred_slow, r.now, reg_slow_k);
                r.valid   = 1'b1;
            end
        end
        r.fast_avg    = pred_fast;
        r.slow_avg    = pred_slow;
        pred_last_occ = occ;
        pred_last_ts  = ts;
        pred_primed   = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("report %0d: %s expected %0h got %0h", reports_seen, field, want, got);
        mismatches = mismatches + 1;
    endtask

    task automatic check_report();
        rate_report_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch("unexpected report", 64'd0, 64'd1);
        end
        else
        begin
            want = expected_reports.pop_front();
            if (result_valid !== want.valid)
                report_mismatch("result_valid", 64'(want.valid), 64'(result_valid));
            if (delta_ns !== want.dns)
                report_mismatch("delta_ns", 64'(want.dns), 64'(delta_ns));
            if (rate_now !== want.now)
                report_mismatch("rate_now", 64'(want.now), 64'(rate_now));
            if (rate_short !== want.fast_avg)
                report_mismatch("rate_short", 64'(want.fast_avg), 64'(rate_short));
            if (rate_long !== want.slow_avg)
                report_mismatch("rate_long", 64'(want.slow_avg), 64'(rate_long));
        end
        reports_seen = reports_seen + 1;
    endtask

    // receiving side: random stall per report, then check it
    initial
    begin : report_side
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, 4);
            if (stall != 0)
            begin
                report_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            report_ready <= 1'b1;
            do @(posedge clk); while (report_valid !== 1'b1);
            check_report();
        end
    end

    // valid stays high after acceptance so a back-to-back request needs no second NBA
    task automatic send_sample(input logic [OCC_W-1:0] occ, input logic [TS_W-1:0] ts);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid      <= 1'b1;
        occupancy_count <= occ;
        timestamp       <= ts;
        do @(posedge clk); while (item_ready !== 1'b1);
        expected_reports.push_back(predict_report(occ, ts));
        stim_occ = occ;
        stim_ts  = ts;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_reports.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MUL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_NS_MUL:    reg_mul    = data;
            REG_NS_DIV:    reg_div    = data;
            REG_SHORT_SHF: reg_fast_k = data[SHIFT_W-1:0];
            REG_LONG_SHF:  reg_slow_k = data[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    // shift writes carry random upper bits, which the block must ignore
    task automatic write_regs(input logic [MUL_W-1:0] mul, input logic [MUL_W-1:0] div,
                              input logic [SHIFT_W-1:0] fast_k,
                              input logic [SHIFT_W-1:0] slow_k);
        cfg_write(REG_NS_MUL, mul);
        cfg_write(REG_NS_DIV, div);
        cfg_write(REG_SHORT_SHF, {12'($urandom), fast_k});
        cfg_write(REG_LONG_SHF, {12'($urandom), slow_k});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_priming();
        send_sample({OCC_W{1'b1}}, {TS_W{1'b1}});
    endtask

    task automatic test_time_edges();
        // zero elapsed time
        send_sample({OCC_W{1'b1}}, {TS_W{1'b1}});
        // both counters wrap by one; one tick rounds down to zero ns
        send_sample('0, '0);
        send_sample(OCC_W'(5), TS_W'(3));
        // occupancy wraps backwards: largest forward distance, rate saturates
        send_sample(OCC_W'(4), TS_W'(6));
        // timestamp distance 2^64-1: elapsed ns saturates
        send_sample(OCC_W'(4), TS_W'(5));
        // 2100 ticks -> 1000 ns: one count below rate saturation, then exactly at it
        send_sample(stim_occ + OCC_W'(65535999), stim_ts + TS_W'(2100));
        send_sample(stim_occ + OCC_W'(65536000), stim_ts + TS_W'(2100));
    endtask

    task automatic test_reg_extremes();
        wait_drained();
        write_regs(16'hFFFF, 16'd1, 4'd0, 4'd15);
        send_sample(stim_occ + (OCC_W'(1) << 30), stim_ts + (TS_W'(1) << 40));
        send_sample(stim_occ + OCC_W'(12345), stim_ts + TS_W'(100));
        wait_drained();
        write_regs(16'd1, 16'hFFFF, 4'd15, 4'd0);
        send_sample(stim_occ + OCC_W'(777), stim_ts + TS_W'(65535));
        send_sample(stim_occ + OCC_W'(5), stim_ts + TS_W'(1000));
        wait_drained();
        // zero multiplier: no time ever elapses
        write_regs(16'd0, 16'd21, 4'd3, 4'd8);
        send_sample(stim_occ + OCC_W'(100), stim_ts + TS_W'(5000));
        wait_drained();
        // zero divisor acts as one
        write_regs(16'd7, 16'd0, 4'd1, 4'd2);
        send_sample(stim_occ + OCC_W'(50), stim_ts + TS_W'(10));
        send_sample(stim_occ + OCC_W'(1), stim_ts + TS_W'(1));
    endtask

    task automatic test_random_traffic(input int count, input logic [MUL_W-1:0] mul,
                                       input logic [MUL_W-1:0] div,
                                       input logic [SHIFT_W-1:0] fast_k,
                                       input logic [SHIFT_W-1:0] slow_k,
                                       input bit pause_midway);
        int               pick;
        logic [TS_W-1:0]  ts_step;
        logic [OCC_W-1:0] occ_step;
        logic [TS_W-1:0]  ts;
        logic [OCC_W-1:0] occ;
        wait_drained();
        write_regs(mul, div, fast_k, slow_k);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                ts_step = '0;
            else if (pick < 35)
                ts_step = TS_W'($urandom_range(1, 64));
            else if (pick < 70)
                ts_step = TS_W'($urandom_range(65, 1 << 20));
            else if (pick < 90)
                ts_step = {24'd0, 8'($urandom), 32'($urandom)};
            else
                ts_step = {$urandom, $urandom} >> $urandom_range(0, 63);

            pick = $urandom_range(0, 99);
            if (pick < 5)
                occ_step = '0;
            else if (pick < 75)
                occ_step = OCC_W'(ts_step[OCC_W-1:0] * $urandom_range(0, 40))
                           + OCC_W'($urandom_range(0, 255));
            else if (pick < 90)
                occ_step = OCC_W'($urandom_range(0, 1000));
            else
                occ_step = OCC_W'({$urandom, $urandom});

            // occasional jump to arbitrary absolute counter values
            ts  = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : stim_ts + ts_step;
            occ = ($urandom_range(0, 19) == 0) ? OCC_W'({$urandom, $urandom})
                                               : stim_occ + occ_step;
            send_sample(occ, ts);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_priming();
        test_time_edges();
        test_reg_extremes();

        test_random_traffic(90, NS_MUL_RST, NS_DIV_RST, SHORT_SHF_RST, LONG_SHF_RST, 1'b1);
        test_random_traffic(70, MUL_W'($urandom_range(1, 65535)),
                            MUL_W'($urandom_range(1, 65535)),
                            SHIFT_W'($urandom), SHIFT_W'($urandom), 1'b0);
        test_random_traffic(70, 16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 1'b0);
        test_random_traffic(70, 16'd1, 16'd1, 4'd0, 4'd0, 1'b0);
        test_random_traffic(80, MUL_W'($urandom), MUL_W'($urandom),
                            SHIFT_W'($urandom), SHIFT_W'($urandom), 1'b1);
        test_random_traffic(70, 16'd3, 16'd7, 4'd4, 4'd12, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
